// ===== sv/rim_pkg.sv =====
// shared types, constants and prefix tables for the id bitmap marker
// no dependencies
package rim_pkg;

  localparam int unsigned CFG_W = 17;
  localparam int unsigned ID_W = 64;
  localparam int unsigned IDX_W = ID_W - 3;

  localparam logic [1:0] REG_NODE_BYTES = 2'd0;
  localparam logic [1:0] REG_WAY_BYTES = 2'd1;
  localparam logic [1:0] REG_REL_BYTES = 2'd2;

  localparam logic [1:0] TYPE_NODE = 2'd0;
  localparam logic [1:0] TYPE_WAY = 2'd1;
  localparam logic [1:0] TYPE_REL = 2'd2;
  localparam logic [1:0] TYPE_NONE = 2'd3;

  localparam logic KIND_MARK = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_LT = 8'h3c;
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_NINE = 8'h39;

  localparam logic [8*32-1:0] MARK_STR0 = "<nd ref=\"";
  localparam logic [8*32-1:0] MARK_STR1 = "<member type=\"node\" ref=\"";
  localparam logic [8*32-1:0] MARK_STR2 = "<member type=\"way\" ref=\"";
  localparam logic [8*32-1:0] MARK_STR3 = "<member type=\"relation\" ref=\"";
  localparam logic [4:0] MARK_LEN [4] = '{5'd9, 5'd25, 5'd24, 5'd29};
  localparam logic [1:0] MARK_TYPE [4] = '{TYPE_NODE, TYPE_NODE, TYPE_WAY, TYPE_REL};

  localparam logic [8*32-1:0] QUERY_STR0 = "<node id=\"";
  localparam logic [8*32-1:0] QUERY_STR1 = "<way id=\"";
  localparam logic [8*32-1:0] QUERY_STR2 = "<relation id=\"";
  localparam logic [4:0] QUERY_LEN [3] = '{5'd10, 5'd9, 5'd14};
  localparam logic [1:0] QUERY_TYPE [3] = '{TYPE_NODE, TYPE_WAY, TYPE_REL};

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [1:0] object_type;
  } out_t;

  // bitmap access or direct answer requested by the parser for one byte
  typedef struct packed {
    logic            go;
    logic            is_set;
    logic            direct;
    logic [1:0]      otype;
    logic [ID_W-1:0] id;
  } op_t;

  // character at a position of a mark prefix, zero past its end
  function automatic logic [7:0] mark_chr(input logic [1:0] c, input logic [4:0] pos);
    logic [8*32-1:0] s;
    logic [7:0] r;
    logic [4:0] len;
    logic [4:0] off;
    r = 8'd0;
    len = MARK_LEN[c];
    case (c)
      2'd0: s = MARK_STR0;
      2'd1: s = MARK_STR1;
      2'd2: s = MARK_STR2;
      default: s = MARK_STR3;
    endcase
    off = 5'(len - 5'd1 - pos);
    if (pos < len) r = s[8*off +: 8];
    return r;
  endfunction

  function automatic logic [7:0] query_chr(input logic [1:0] c, input logic [4:0] pos);
    logic [8*32-1:0] s;
    logic [7:0] r;
    logic [4:0] len;
    logic [4:0] off;
    r = 8'd0;
    len = 5'd0;
    s = '0;
    case (c)
      2'd0: begin s = QUERY_STR0; len = QUERY_LEN[0]; end
      2'd1: begin s = QUERY_STR1; len = QUERY_LEN[1]; end
      2'd2: begin s = QUERY_STR2; len = QUERY_LEN[2]; end
      default: begin s = '0; len = 5'd0; end
    endcase
    off = 5'(len - 5'd1 - pos);
    if (pos < len) r = s[8*off +: 8];
    return r;
  endfunction

endpackage

// ===== sv/rim_flag_mem.sv =====
// one flag bitmap: single write port, one registered read port
// no dependencies
module rim_flag_mem #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rim_mod_unit.sv =====
// iterative restoring remainder unit, one dividend bit per cycle
// depends on rim_pkg
module rim_mod_unit #(
  parameter int unsigned SIZE_W = 17
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rim_pkg::IDX_W-1:0] dividend_i,
  input  logic [SIZE_W-1:0]        divisor_i,
  output logic                     done_o,
  output logic [SIZE_W-1:0]        rem_o
);

  localparam int unsigned CntW = $clog2(rim_pkg::IDX_W);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [rim_pkg::IDX_W-1:0] dvd_q, dvd_d;
  logic [SIZE_W-1:0]         div_q, div_d;
  logic [SIZE_W-1:0]         rem_q, rem_d;
  logic [SIZE_W:0]           trial;
  logic [SIZE_W:0]           diff;

  always_comb begin
    trial = {rem_q, dvd_q[rim_pkg::IDX_W-1]};
    diff = trial - {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    div_d = div_q;
    rem_d = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = CntW'(rim_pkg::IDX_W - 1);
      dvd_d = dividend_i;
      div_d = divisor_i;
      rem_d = '0;
    end else if (busy_q) begin
      // remainder stays below divisor, so it fits the narrow register
      rem_d = (trial >= {1'b0, div_q}) ? SIZE_W'(diff) : SIZE_W'(trial);
      dvd_d = {dvd_q[rim_pkg::IDX_W-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o = rem_q;

endmodule

// ===== sv/rim_parser.sv =====
// byte parser: quote parity, prefix matching and decimal id accumulation
// depends on rim_pkg
module rim_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  rim_pkg::in_t  in_i,
  output rim_pkg::op_t  op_o
);

  logic                     qp_q, qp_d;
  logic [4:0]               pos_q, pos_d;
  logic [3:0]               cand_q, cand_d;
  logic [1:0]               pt_q, pt_d;
  logic                     dig_q, dig_d;
  logic                     dec_q, dec_d;
  logic [rim_pkg::ID_W-1:0] id_q, id_d;

  always_comb begin
    logic                     s_qp;
    logic [4:0]               s_pos;
    logic [3:0]               s_cand;
    logic [1:0]               s_pt;
    logic                     s_dig;
    logic                     s_dec;
    logic [rim_pkg::ID_W-1:0] s_id;
    logic [7:0]               b;
    logic                     is_dig;
    logic [rim_pkg::ID_W-1:0] acc;
    logic [3:0]               mk_keep, mk_full;
    logic [3:0]               q_cand, q_keep, q_full;
    logic                     go_on, plain;
    logic [1:0]               mk_done, q_done;
    rim_pkg::op_t             op;

    b = in_i.byte_value;
    s_qp = in_i.first_byte ? 1'b0 : qp_q;
    s_pos = in_i.first_byte ? 5'd0 : pos_q;
    s_cand = in_i.first_byte ? 4'd0 : cand_q;
    s_pt = in_i.first_byte ? 2'd0 : pt_q;
    s_dig = in_i.first_byte ? 1'b0 : dig_q;
    s_dec = in_i.first_byte ? 1'b0 : dec_q;
    s_id = in_i.first_byte ? '0 : id_q;

    is_dig = (b >= rim_pkg::CHR_ZERO) && (b <= rim_pkg::CHR_NINE);
    // times ten as two shifted copies, plus the digit
    acc = {s_id[rim_pkg::ID_W-4:0], 3'b000} + {s_id[rim_pkg::ID_W-2:0], 1'b0}
        + rim_pkg::ID_W'(4'(b - rim_pkg::CHR_ZERO));

    // candidate narrowing, all four prefixes side by side
    q_cand = (s_pos == 5'd0) ? 4'b0111 : s_cand;
    for (int c = 0; c < 4; c++) begin
      mk_keep[c] = s_cand[c] && (s_pos < rim_pkg::MARK_LEN[c])
                 && (rim_pkg::mark_chr(2'(c), s_pos) == b);
      mk_full[c] = mk_keep[c] && (5'(s_pos + 5'd1) == rim_pkg::MARK_LEN[c]);
      if (c < 3) begin
        q_keep[c] = q_cand[c] && (s_pos < rim_pkg::QUERY_LEN[c])
                  && (rim_pkg::query_chr(2'(c), s_pos) == b);
        q_full[c] = q_keep[c] && (5'(s_pos + 5'd1) == rim_pkg::QUERY_LEN[c]);
      end else begin
        q_keep[c] = 1'b0;
        q_full[c] = 1'b0;
      end
    end
    mk_done = mk_full[0] ? 2'd0 : mk_full[1] ? 2'd1 : mk_full[2] ? 2'd2 : 2'd3;
    q_done = q_full[0] ? 2'd0 : q_full[1] ? 2'd1 : 2'd2;

    op.go = 1'b0;
    op.is_set = 1'b0;
    op.direct = 1'b0;
    op.otype = s_pt;
    op.id = s_id;
    go_on = 1'b1;
    plain = 1'b0;

    if (in_i.kind == rim_pkg::KIND_MARK) begin
      if (s_dig) begin
        if (is_dig) begin
          s_id = acc;
          go_on = 1'b0;
          if (in_i.last_byte) begin
            op.go = 1'b1;
            op.is_set = 1'b1;
            op.id = acc;
            s_dig = 1'b0;
          end
        end else begin
          op.go = 1'b1;
          op.is_set = 1'b1;
          s_dig = 1'b0;
        end
      end
      if (go_on) begin
        if (s_cand != 4'd0) begin
          if (mk_full != 4'd0) begin
            s_pt = rim_pkg::MARK_TYPE[mk_done];
            s_cand = 4'd0;
            s_pos = 5'd0;
            s_qp = 1'b1;
            s_id = '0;
            s_dig = 1'b1;
            if (in_i.last_byte) begin
              op.go = 1'b1;
              op.is_set = 1'b1;
              op.otype = s_pt;
              op.id = '0;
              s_dig = 1'b0;
            end
          end else if (mk_keep != 4'd0) begin
            s_cand = mk_keep;
            s_pos = 5'(s_pos + 5'd1);
            if (b == rim_pkg::CHR_QUOTE) s_qp = ~s_qp;
          end else begin
            s_cand = 4'd0;
            s_pos = 5'd0;
            plain = 1'b1;
          end
        end else begin
          plain = 1'b1;
        end
        if (plain) begin
          if (b == rim_pkg::CHR_QUOTE) begin
            s_qp = ~s_qp;
          end else if (!s_qp && (b == rim_pkg::CHR_LT)) begin
            s_cand = 4'hf;
            s_pos = 5'd1;
          end
        end
      end
    end else if (!s_dec) begin
      if (s_dig) begin
        if (is_dig) s_id = acc;
        if (!is_dig || in_i.last_byte) begin
          op.go = 1'b1;
          op.id = s_id;
          s_dec = 1'b1;
          s_dig = 1'b0;
        end
      end else if (q_full != 4'd0) begin
        s_pt = rim_pkg::QUERY_TYPE[q_done];
        s_cand = 4'd0;
        s_pos = 5'd0;
        s_id = '0;
        s_dig = 1'b1;
        if (in_i.last_byte) begin
          op.go = 1'b1;
          op.otype = s_pt;
          op.id = '0;
          s_dec = 1'b1;
          s_dig = 1'b0;
        end
      end else if (q_keep != 4'd0) begin
        s_cand = q_keep;
        s_pos = 5'(s_pos + 5'd1);
        if (in_i.last_byte) begin
          op.direct = 1'b1;
          s_dec = 1'b1;
          s_dig = 1'b0;
        end
      end else begin
        s_cand = 4'd0;
        s_pos = 5'd0;
        op.direct = 1'b1;
        s_dec = 1'b1;
        s_dig = 1'b0;
      end
    end

    // string end clears the parser
    if (in_i.last_byte) begin
      s_qp = 1'b0;
      s_pos = 5'd0;
      s_cand = 4'd0;
      s_pt = 2'd0;
      s_dig = 1'b0;
      s_dec = 1'b0;
      s_id = '0;
    end

    qp_d = s_qp;
    pos_d = s_pos;
    cand_d = s_cand;
    pt_d = s_pt;
    dig_d = s_dig;
    dec_d = s_dec;
    id_d = s_id;
    op_o = op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qp_q <= 1'b0;
      pos_q <= 5'd0;
      cand_q <= 4'd0;
      pt_q <= 2'd0;
      dig_q <= 1'b0;
      dec_q <= 1'b0;
      id_q <= '0;
    end else if (take_i) begin
      qp_q <= qp_d;
      pos_q <= pos_d;
      cand_q <= cand_d;
      pt_q <= pt_d;
      dig_q <= dig_d;
      dec_q <= dec_d;
      id_q <= id_d;
    end
  end

endmodule

// ===== sv/ref_id_bitmap_marker.sv =====
// top level of the id bitmap marker: sequencer, config registers, bitmaps
// depends on rim_pkg, rim_parser, rim_mod_unit, rim_flag_mem

// Takes one text byte per input beat. A byte that needs no bitmap access
// (most bytes) leaves the sequencer idle, and a query answer that needs no
// lookup is ready the cycle after. A byte that ends a reference id or a
// query id is accepted, then the serial remainder unit folds id/8 into the
// configured bitmap size (one bit of the 61-bit byte index per cycle), the
// remainder is handed to the address register, the registered bitmap read
// follows, and last comes the read-modify-write or the answer; no new byte
// is taken meanwhile. After reset the three bitmaps are cleared one entry
// per cycle and no byte is taken meanwhile; config writes are taken at any
// time. Sizes of zero read as one, sizes above MAP_BYTES read as MAP_BYTES.
module ref_id_bitmap_marker #(
  parameter int unsigned MAP_BYTES = 65536
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rim_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rim_pkg::out_t             out_data_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [rim_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(MAP_BYTES);
  localparam int unsigned SizeW = $clog2(MAP_BYTES + 1);
  localparam int unsigned CmpW = (SizeW > rim_pkg::CFG_W) ? SizeW : rim_pkg::CFG_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_RD    = 5'b01000,
    ST_WR    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // config registers, raw as written
  logic [rim_pkg::CFG_W-1:0] node_bytes_q, way_bytes_q, rel_bytes_q;

  logic          take;
  rim_pkg::op_t  op;
  logic          op_set_q;
  logic [1:0]    op_type_q;
  logic [2:0]    op_bit_q;
  logic [AddrW-1:0] addr_q, clr_cnt_q;

  logic             out_valid_q, out_valid_d;
  rim_pkg::out_t    out_data_q, out_data_d;

  logic [rim_pkg::CFG_W-1:0] raw_size;
  logic [CmpW-1:0]           raw_x;
  logic [SizeW-1:0]          eff_size;
  logic                      mod_done;
  logic [SizeW-1:0]          mod_rem;

  logic [2:0]       mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [7:0]       rd_node, rd_way, rd_rel, rd_sel;

  // a beat is taken only when the output is free or being drained
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign take = in_valid_i && in_ready_o;

  rim_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .in_i   (in_data_i),
    .op_o   (op)
  );

  // saturated bitmap size for the type of the new access
  always_comb begin
    case (op.otype)
      rim_pkg::TYPE_WAY: raw_size = way_bytes_q;
      rim_pkg::TYPE_REL: raw_size = rel_bytes_q;
      default:           raw_size = node_bytes_q;
    endcase
    raw_x = CmpW'(raw_size);
    if (raw_x == '0) begin
      eff_size = SizeW'(1);
    end else if (raw_x > CmpW'(MAP_BYTES)) begin
      eff_size = SizeW'(MAP_BYTES);
    end else begin
      eff_size = SizeW'(raw_x);
    end
  end

  rim_mod_unit #(
    .SIZE_W (SizeW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (take && op.go),
    .dividend_i (op.id[rim_pkg::ID_W-1:3]),
    .divisor_i  (eff_size),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // bitmaps: clearing sweep writes all three, otherwise only the op's type
  always_comb begin
    case (op_type_q)
      rim_pkg::TYPE_WAY: rd_sel = rd_way;
      rim_pkg::TYPE_REL: rd_sel = rd_rel;
      default:           rd_sel = rd_node;
    endcase
    mem_we = 3'b000;
    mem_waddr = addr_q;
    mem_wdata = rd_sel | (8'd1 << op_bit_q);
    if (state_q == ST_CLEAR) begin
      mem_we = 3'b111;
      mem_waddr = clr_cnt_q;
      mem_wdata = 8'd0;
    end else if ((state_q == ST_WR) && op_set_q) begin
      case (op_type_q)
        rim_pkg::TYPE_WAY: mem_we = 3'b010;
        rim_pkg::TYPE_REL: mem_we = 3'b100;
        default:           mem_we = 3'b001;
      endcase
      mem_wdata = rd_sel | (8'd1 << op_bit_q);
    end
  end

  rim_flag_mem #(.DEPTH(MAP_BYTES)) u_node_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we[0]),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q),
    .rdata_o (rd_node)
  );

  rim_flag_mem #(.DEPTH(MAP_BYTES)) u_way_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we[1]),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q),
    .rdata_o (rd_way)
  );

  rim_flag_mem #(.DEPTH(MAP_BYTES)) u_rel_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we[2]),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q),
    .rdata_o (rd_rel)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d = out_data_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == AddrW'(MAP_BYTES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) begin
          if (op.go) begin
            state_d = ST_DIV;
          end else if (op.direct) begin
            // query with no complete prefix, answered without lookup
            out_valid_d = 1'b1;
            out_data_d.found = 1'b0;
            out_data_d.object_type = rim_pkg::TYPE_NONE;
          end
        end
      end
      ST_DIV: begin
        if (mod_done) state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        state_d = ST_IDLE;
        if (!op_set_q) begin
          out_valid_d = 1'b1;
          out_data_d.found = rd_sel[op_bit_q];
          out_data_d.object_type = op_type_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_cnt_q <= '0;
      out_valid_q <= 1'b0;
      node_bytes_q <= rim_pkg::CFG_W'(65536);
      way_bytes_q <= rim_pkg::CFG_W'(65536);
      rel_bytes_q <= rim_pkg::CFG_W'(65536);
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + AddrW'(1);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rim_pkg::REG_NODE_BYTES: node_bytes_q <= cfg_wdata_i;
          rim_pkg::REG_WAY_BYTES:  way_bytes_q <= cfg_wdata_i;
          rim_pkg::REG_REL_BYTES:  rel_bytes_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (take && op.go) begin
      op_set_q <= op.is_set;
      op_type_q <= op.otype;
      op_bit_q <= op.id[2:0];
    end
    if (mod_done) addr_q <= AddrW'(mod_rem);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE))
    else $error("input ready outside idle");

  a_query_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WR) && !op_set_q) |=> out_valid_o)
    else $error("lookup finished without an answer");

  a_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we != 3'b000) |-> ((state_q == ST_CLEAR) || (state_q == ST_WR)))
    else $error("bitmap written outside clear or update");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == ST_DIV))
    else $error("remainder done outside divide phase");
`endif

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for ref_id_bitmap_marker: text beats in, query answers out
// depends on rim_pkg and the block; has its own bitmap predictor
`timescale 1ns / 100ps

module testbench;

  localparam int MAP_ENTRIES = 65536;
  localparam int CYCLE_LIMIT = 1000000;
  // a byte that closes an id keeps the block busy after it is taken
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_BEATS = 320;
  localparam int TOTAL_BEATS = 1900;
  // index past the register list, the block must ignore it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  rim_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rim_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [rim_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  ref_id_bitmap_marker dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------
  // predictor: parser state, sizes and the three bitmaps
  // ---------------------------------------------------------------
  string ref_prefix[4] = '{"<nd ref=\"", "<member type=\"node\" ref=\"",
                           "<member type=\"way\" ref=\"",
                           "<member type=\"relation\" ref=\""};
  logic [1:0] ref_kind[4] = '{rim_pkg::TYPE_NODE, rim_pkg::TYPE_NODE,
                              rim_pkg::TYPE_WAY, rim_pkg::TYPE_REL};
  string id_prefix[3] = '{"<node id=\"", "<way id=\"", "<relation id=\""};

  logic [rim_pkg::CFG_W-1:0] map_size[3];
  bit [7:0] flag_mem[3][MAP_ENTRIES];

  bit in_quote;
  logic [4:0] match_pos;
  logic [3:0] match_set;
  logic [1:0] id_type;
  bit in_digits;
  bit answered;
  logic [63:0] id_value;

  rim_pkg::out_t answer_q[$];
  int errors = 0;

  function automatic void clear_parser();
    in_quote = 0;
    match_pos = '0;
    match_set = '0;
    id_type = rim_pkg::TYPE_NODE;
    in_digits = 0;
    answered = 0;
    id_value = '0;
  endfunction

  function automatic int map_slot(logic [1:0] t, logic [63:0] id);
    logic [63:0] n;
    n = map_size[t];
    if (n == 0) n = 1;
    if (n > MAP_ENTRIES) n = MAP_ENTRIES;
    return int'((id >> 3) % n);
  endfunction

  function automatic void mark_id(logic [1:0] t, logic [63:0] id);
    flag_mem[t][map_slot(t, id)][id[2:0]] = 1'b1;
  endfunction

  function automatic bit flag_of(logic [1:0] t, logic [63:0] id);
    return flag_mem[t][map_slot(t, id)][id[2:0]];
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= rim_pkg::CHR_ZERO && b <= rim_pkg::CHR_NINE;
  endfunction

  // keeps prefixes that carry b at match position, done gets the first completed
  function automatic logic [3:0] narrow(bit qry, logic [3:0] cand, logic [7:0] b,
                                        output int done);
    logic [3:0] keep;
    string s;
    keep = '0;
    done = -1;
    for (int c = 0; c < 4; c++) begin
      if (!cand[c] || (qry && c == 3)) continue;
      s = qry ? id_prefix[c] : ref_prefix[c];
      if (match_pos >= s.len() || s[match_pos] != b) continue;
      keep[c] = 1'b1;
      if (match_pos + 1 == s.len() && done < 0) done = c;
    end
    return keep;
  endfunction

  function automatic void mark_beat(logic [7:0] b, bit last);
    int done;
    logic [3:0] keep;
    if (in_digits) begin
      if (is_digit(b)) begin
        id_value = id_value * 10 + 64'(b - rim_pkg::CHR_ZERO);
        if (last) begin
          mark_id(id_type, id_value);
          in_digits = 0;
        end
        return;
      end
      mark_id(id_type, id_value);
      in_digits = 0;
    end
    if (match_set != 0) begin
      keep = narrow(0, match_set, b, done);
      if (done >= 0) begin
        id_type = ref_kind[done];
        match_set = '0;
        match_pos = '0;
        in_quote = 1;
        id_value = '0;
        in_digits = 1;
        if (last) begin
          mark_id(id_type, 64'd0);
          in_digits = 0;
        end
        return;
      end
      if (keep != 0) begin
        match_set = keep;
        match_pos = match_pos + 5'd1;
        if (b == rim_pkg::CHR_QUOTE) in_quote = !in_quote;
        return;
      end
      match_set = '0;
      match_pos = '0;
    end
    if (b == rim_pkg::CHR_QUOTE) begin
      in_quote = !in_quote;
    end else if (!in_quote && b == rim_pkg::CHR_LT) begin
      match_set = 4'hf;
      match_pos = 5'd1;
    end
  endfunction

  function automatic void give_answer(bit hit, logic [1:0] t);
    rim_pkg::out_t r;
    r.found = hit;
    r.object_type = t;
    answer_q.push_back(r);
    answered = 1;
    in_digits = 0;
  endfunction

  function automatic void query_beat(logic [7:0] b, bit last);
    int done;
    logic [3:0] keep;
    if (answered) return;
    if (in_digits) begin
      if (is_digit(b)) begin
        id_value = id_value * 10 + 64'(b - rim_pkg::CHR_ZERO);
        if (!last) return;
      end
      give_answer(flag_of(id_type, id_value), id_type);
      return;
    end
    keep = narrow(1, (match_pos == 0) ? 4'h7 : match_set, b, done);
    if (done >= 0) begin
      id_type = ref_kind[0];
      id_type = done[1:0];
      match_set = '0;
      match_pos = '0;
      id_value = '0;
      in_digits = 1;
      if (last) give_answer(flag_of(id_type, 64'd0), id_type);
      return;
    end
    if (keep != 0) begin
      match_set = keep;
      match_pos = match_pos + 5'd1;
      if (last) give_answer(1'b0, rim_pkg::TYPE_NONE);
      return;
    end
    match_set = '0;
    match_pos = '0;
    give_answer(1'b0, rim_pkg::TYPE_NONE);
  endfunction

  function automatic void predict_beat(rim_pkg::in_t d);
    if (d.first_byte) clear_parser();
    if (d.kind == rim_pkg::KIND_MARK) mark_beat(d.byte_value, d.last_byte);
    else query_beat(d.byte_value, d.last_byte);
    if (d.last_byte) clear_parser();
  endfunction

  // ---------------------------------------------------------------
  // driver, responder and scoreboard
  // ---------------------------------------------------------------
  rim_pkg::in_t pending[$];
  bit no_idle;
  int send_gap;
  int recv_wait;
  int cycles = 0;

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending.size() != 0) begin
        in_data_i <= pending.pop_front();
        in_valid_i <= 1'b1;
        send_gap <= draw_wait();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait <= 0;
    end else if (out_valid_o && out_ready_i) begin
      w = draw_wait();
      recv_wait <= w;
      out_ready_i <= (w == 0);
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_ready_i <= (recv_wait == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // input beats feed the predictor, output beats are checked against it
  always @(posedge clk_i) begin
    rim_pkg::out_t want;
    if (rst_ni && in_valid_i && in_ready_o) predict_beat(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected answer, expected none, actual found=%0d type=%0d",
                 $time, out_data_o.found, out_data_o.object_type);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (out_data_o.found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found,
                   out_data_o.found);
          errors++;
        end
        if (out_data_o.object_type !== want.object_type) begin
          $display("%0t: object_type expected %0d actual %0d", $time,
                   want.object_type, out_data_o.object_type);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus: text frames built byte by byte
  // ---------------------------------------------------------------
  logic [7:0] text[$];
  string id_pool[3][$];
  int beats_sent = 0;

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  // decimal id: mostly short, now and then past 64 bits
  function automatic string rand_digits();
    string s;
    int n;
    s = "";
    case ($urandom_range(0, 9))
      0: n = 0;
      1: n = $urandom_range(19, 24);
      default: n = $urandom_range(1, 6);
    endcase
    for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
    return s;
  endfunction

  function automatic void add_noise();
    logic [7:0] pick[6] = '{rim_pkg::CHR_QUOTE, rim_pkg::CHR_LT, "a", "7", " ", 8'h00};
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 2) == 0) text.push_back(8'($urandom_range(0, 255)));
      else text.push_back(pick[$urandom_range(0, 5)]);
    end
  endfunction

  // hands the frame to the driver; mix flips the kind of a few bytes
  function automatic void send_text(logic kind, bit with_first, bit with_last, bit mix);
    rim_pkg::in_t d;
    for (int i = 0; i < text.size(); i++) begin
      d.kind = (mix && $urandom_range(0, 9) == 0) ? !kind : kind;
      d.byte_value = text[i];
      d.first_byte = (i == 0) ? with_first : ($urandom_range(0, 199) == 0);
      d.last_byte = (i == text.size() - 1) ? with_last : ($urandom_range(0, 199) == 0);
      pending.push_back(d);
    end
    beats_sent += text.size();
    text.delete();
  endfunction

  function automatic void directed(logic kind, string s, bit with_last = 1);
    add_text(s);
    send_text(kind, 1, with_last, 0);
  endfunction

  function automatic void rand_ref_frame();
    int k;
    string ds;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        add_noise();
      end else begin
        k = $urandom_range(0, 3);
        if ($urandom_range(0, 6) == 0) begin
          // broken reference: cut short, then junk
          add_text(ref_prefix[k].substr(0, $urandom_range(0, ref_prefix[k].len() - 2)));
          add_noise();
        end else begin
          ds = rand_digits();
          add_text(ref_prefix[k]);
          add_text(ds);
          id_pool[ref_kind[k]].push_back(ds);
          if ($urandom_range(0, 3) != 0) add_text("\"/>");
        end
      end
    end
    send_text(rim_pkg::KIND_MARK, $urandom_range(0, 11) != 0, $urandom_range(0, 9) != 0,
              $urandom_range(0, 9) == 0);
  endfunction

  function automatic void rand_query_frame();
    int t;
    t = $urandom_range(0, 2);
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1) == 0) add_noise();
      else add_text(id_prefix[t].substr(0, $urandom_range(0, id_prefix[t].len() - 2)));
    end else begin
      add_text(id_prefix[t]);
      if (id_pool[t].size() != 0 && $urandom_range(0, 9) < 7)
        add_text(id_pool[t][$urandom_range(0, id_pool[t].size() - 1)]);
      else
        add_text(rand_digits());
      if ($urandom_range(0, 1) == 0) add_text("\"");
      if ($urandom_range(0, 3) == 0) add_noise();
    end
    send_text(rim_pkg::KIND_QUERY, $urandom_range(0, 11) != 0, $urandom_range(0, 9) != 0,
              $urandom_range(0, 9) == 0);
  endfunction

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid_i || answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [rim_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx != REG_UNUSED) map_size[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int phase;
    logic [rim_pkg::CFG_W-1:0] sz;
    for (int t = 0; t < 3; t++) map_size[t] = rim_pkg::CFG_W'(MAP_ENTRIES);
    clear_parser();
    no_idle = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes right after reset: zero reads as one, oversize saturates
    write_reg(rim_pkg::REG_NODE_BYTES, '0);
    write_reg(rim_pkg::REG_WAY_BYTES, '1);
    write_reg(rim_pkg::REG_REL_BYTES, rim_pkg::CFG_W'(MAP_ENTRIES));
    write_reg(REG_UNUSED, 17'd5);

    // directed frames: all prefixes, id extremes, quoting and framing cases
    directed(rim_pkg::KIND_MARK, "<nd ref=\"42\"/>");
    directed(rim_pkg::KIND_MARK, "<member type=\"node\" ref=\"1000\"/>");
    directed(rim_pkg::KIND_MARK, "<member type=\"way\" ref=\"18446744073709551615\"/>");
    directed(rim_pkg::KIND_MARK, "<member type=\"relation\" ref=\"18446744073709551623\"");
    directed(rim_pkg::KIND_MARK, "<nd ref=\"\"");
    directed(rim_pkg::KIND_MARK, "a=\"<nd ref=\"77\"");
    directed(rim_pkg::KIND_MARK, "<nd rex\"<nd ref=\"8\"<nd ref=\"9\"");
    directed(rim_pkg::KIND_MARK, "<member type=\"way\" ref=\"123");
    directed(rim_pkg::KIND_MARK, "<nd ref=\"55", 0);
    directed(rim_pkg::KIND_QUERY, "<node id=\"55\"");
    directed(rim_pkg::KIND_QUERY, "<node id=\"42\"");
    directed(rim_pkg::KIND_QUERY, "<way id=\"18446744073709551615\" tail");
    directed(rim_pkg::KIND_QUERY, "<relation id=\"7\"");
    directed(rim_pkg::KIND_QUERY, "<way id=\"123");
    directed(rim_pkg::KIND_QUERY, "<node id=\"");
    directed(rim_pkg::KIND_QUERY, "<foo");
    directed(rim_pkg::KIND_QUERY, "<rel");
    directed(rim_pkg::KIND_QUERY, "<node id=\"77\"");
    text.push_back(8'h00);
    add_text("<nd ref=\"3\"");
    text.push_back(8'hff);
    send_text(rim_pkg::KIND_MARK, 1, 1, 0);
    add_text("<nd ref=\"600\"");
    send_text(rim_pkg::KIND_MARK, 0, 1, 1);
    directed(rim_pkg::KIND_QUERY, "<node id=\"3\"");
    add_text("<way id=\"5\"");
    send_text(rim_pkg::KIND_QUERY, 0, 1, 1);

    phase = 0;
    while (beats_sent < TOTAL_BEATS) begin
      // sender holds off until every answer is back, then sizes change
      wait_idle();
      for (int t = 0; t < 3; t++) begin
        case (phase % 4)
          0: sz = rim_pkg::CFG_W'($urandom_range(1, 16));
          1: sz = 17'd1;
          2: sz = rim_pkg::CFG_W'($urandom_range(1, MAP_ENTRIES));
          default: sz = ($urandom_range(0, 1) != 0) ? '1 : rim_pkg::CFG_W'(MAP_ENTRIES);
        endcase
        write_reg(t[1:0], sz);
      end
      no_idle = (phase % 3 == 2);
      while (beats_sent < (phase + 1) * PHASE_BEATS + 200 && beats_sent < TOTAL_BEATS) begin
        if ($urandom_range(0, 9) < 5) rand_ref_frame();
        else rand_query_frame();
      end
      phase++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
